@@ hdl/hrco_pkg.sv @@
// hrco_pkg: shared types and constants of the request check / end offset block.
// Holds the transaction structs, mode, status and register codes and the
// multiplier request/response structs. No dependencies.
package hrco_pkg;

  localparam int unsigned MAX_DIMS = 8;
  localparam int unsigned DIM_W    = $clog2(MAX_DIMS + 1);

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 62;

  // mode codes
  localparam logic [1:0] FUNC_OFFSET = 2'd0;
  localparam logic [1:0] FUNC_EDGE   = 2'd1;
  localparam logic [1:0] FUNC_STRIDE = 2'd2;
  localparam logic [1:0] FUNC_NONE   = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_COORD  = 2'd1;
  localparam logic [1:0] ST_EDGE   = 2'd2;
  localparam logic [1:0] ST_STRIDE = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NUM_DIMS    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RECORD_VAR  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WIDE_FORMAT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ELEM_SIZE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_VAR_BEGIN   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RECORD_SIZE = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_RECORDS = 3'd6;

  typedef struct packed {
    logic [1:0]         func;
    logic               is_read;
    logic               has_counts;
    logic               has_strides;
    logic signed [63:0] dim_start;
    logic signed [63:0] dim_count;
    logic signed [63:0] dim_stride;
    logic signed [63:0] dim_extent;
    logic [47:0]        dim_pitch;
    logic               is_last;
  } hrco_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [63:0] end_offset;
  } hrco_out_t;

  typedef struct packed {
    logic        start;
    logic [63:0] a;
    logic [63:0] b;
  } mul_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [63:0] p;
  } mul_rsp_t;

endpackage

@@ hdl/hrco_mul.sv @@
// hrco_mul: 64 x 64 multiplier, product modulo 2^64, on one 32 x 32 multiplier.
// Three partial products, summed in turn into the accumulator; done pulses for one cycle.
// Depends on hrco_pkg.
module hrco_mul
  import hrco_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  mul_req_t req_i,
  output mul_rsp_t rsp_o
);

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [1:0]  step_q, step_d;
  logic [63:0] a_q, b_q;
  logic [63:0] prod_q, prod_d;
  logic [63:0] acc_q, acc_d;
  logic [31:0] opa, opb;

  always_comb begin
    opa = (step_q == 2'd2) ? a_q[63:32] : a_q[31:0];
    opb = (step_q == 2'd1) ? b_q[63:32] : b_q[31:0];
    prod_d = {32'd0, opa} * {32'd0, opb};
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    acc_d  = acc_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      step_d = 2'd0;
    end else if (busy_q) begin
      step_d = step_q + 2'd1;
      case (step_q)
        2'd0: acc_d = acc_q;
        2'd1: acc_d = prod_q;
        2'd2: acc_d = acc_q + {prod_q[31:0], 32'd0};
        2'd3: begin
          acc_d  = acc_q + {prod_q[31:0], 32'd0};
          busy_d = 1'b0;
          done_d = 1'b1;
        end
        default: acc_d = acc_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= 2'd0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      a_q <= req_i.a;
      b_q <= req_i.b;
    end
    prod_q <= prod_d;
    acc_q  <= acc_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.p    = acc_q;

  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q)
    else $error("multiplier started while busy");

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("done held for more than one cycle");

  a_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && step_q == 2'd3 && !req_i.start) |=> (done_q && !busy_q))
    else $error("multiplier did not finish after last step");

endmodule

@@ hdl/hyperslab_request_check_offset_core.sv @@
// hyperslab_request_check_offset_core: per-dimension request checker and end offset.
// Sequencer, check logic and offset accumulator around the shared hrco_mul.
// Depends on hrco_pkg and hrco_mul.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+------------------------
//  in      | input     | in_valid_i/in_ready_o  | in_data_i  (hrco_in_t)
//  out     | output    | out_valid_o/out_ready_i| out_data_o (hrco_out_t)
//  cfg     | input     | cfg_we_i               | cfg_idx_i, cfg_wdata_i
//
// One dimension transaction at a time; ready only while the sequencer is idle.
// Edge check (mode 1) needs no product. Each 64-bit product runs on the shared
// 32 x 32 multiplier: mode 2 needs one product, mode 0 up to three (stride,
// pitch, element size). Items past the dimension count or after an error go
// straight to the finish step.
// The result register frees the input side; a closing item waits only while
// an earlier result is still held. Reset clears control and result registers.
module hyperslab_request_check_offset_core
  import hrco_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  hrco_in_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output hrco_out_t             out_data_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  typedef enum logic [2:0] {
    S_IDLE, S_DEC, S_MUL1, S_SUM, S_CHECK, S_MUL2, S_FIN
  } state_e;

  localparam logic signed [63:0] REC_LIMIT = 64'sh0000_0000_FFFF_FFFF;

  // configuration
  logic [3:0]  num_dims_q;
  logic        record_var_q;
  logic        wide_format_q;
  logic [3:0]  elem_size_q;
  logic [61:0] var_begin_q;
  logic [47:0] record_size_q;
  logic [61:0] num_records_q;

  state_e             state_q, state_d;
  logic [DIM_W-1:0]   dim_q, dim_d;
  logic [1:0]         sticky_q, sticky_d;
  logic [63:0]        offs_q, offs_d;
  logic               scale_q, scale_d;
  logic               out_valid_q, out_valid_d;
  hrco_out_t          out_data_q, out_data_d;

  hrco_in_t           in_q, in_d;
  logic [63:0]        dm1_q, dm1_d;
  logic [63:0]        prod_q, prod_d;
  logic [63:0]        sum_q, sum_d;

  logic [DIM_W-1:0]   nd;
  logic               rec, last;
  logic [1:0]         chk;
  logic [63:0]        addend;
  logic               cin;
  logic signed [63:0] endv;
  mul_req_t           mreq;
  mul_rsp_t           mrsp;

  hrco_mul u_mul (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (mreq),
    .rsp_o (mrsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_dims_q    <= 4'd0;
      record_var_q  <= 1'b0;
      wide_format_q <= 1'b0;
      elem_size_q   <= 4'd1;
      var_begin_q   <= '0;
      record_size_q <= '0;
      num_records_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_NUM_DIMS:    num_dims_q    <= cfg_wdata_i[3:0];
        REG_RECORD_VAR:  record_var_q  <= cfg_wdata_i[0];
        REG_WIDE_FORMAT: wide_format_q <= cfg_wdata_i[0];
        REG_ELEM_SIZE:   elem_size_q   <= cfg_wdata_i[3:0];
        REG_VAR_BEGIN:   var_begin_q   <= cfg_wdata_i;
        REG_RECORD_SIZE: record_size_q <= cfg_wdata_i[47:0];
        REG_NUM_RECORDS: num_records_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // effective dimension count and position flags
  always_comb begin
    if (32'(num_dims_q) > 32'(MAX_DIMS)) begin
      nd = DIM_W'(MAX_DIMS);
    end else begin
      nd = DIM_W'(num_dims_q);
    end
    rec  = record_var_q && (dim_q == '0);
    last = (32'(dim_q) + 32'd1) == 32'(nd);
    endv = $signed(sum_q);
  end

  // checks on the registered end index / edge sum
  always_comb begin
    chk = ST_OK;
    case (in_q.func)
      FUNC_OFFSET: begin
        if (rec) begin
          if ((!wide_format_q && endv > REC_LIMIT) ||
              (in_q.is_read && endv >= $signed({2'b00, num_records_q}))) begin
            chk = ST_COORD;
          end
        end else if (endv < 0 || endv >= in_q.dim_extent) begin
          chk = ST_COORD;
        end
      end
      FUNC_EDGE: begin
        if (rec) begin
          if (in_q.dim_start < 0) chk = ST_EDGE;
        end else if (in_q.dim_extent < 0 || in_q.dim_count > in_q.dim_extent ||
                     in_q.dim_start < 0 || endv > in_q.dim_extent) begin
          chk = ST_EDGE;
        end
      end
      FUNC_STRIDE: begin
        if (rec) begin
          if (in_q.dim_stride == '0) chk = ST_STRIDE;
        end else if (in_q.dim_extent < 0 || in_q.dim_count > in_q.dim_extent) begin
          chk = ST_EDGE;
        end else if (in_q.dim_count > 0 && endv > in_q.dim_extent) begin
          chk = ST_EDGE;
        end else if (in_q.dim_count == '0 && in_q.dim_start > in_q.dim_extent) begin
          chk = ST_EDGE;
        end else if (in_q.dim_stride == '0) begin
          chk = ST_STRIDE;
        end
      end
      default: chk = ST_OK;
    endcase
  end

  // adder operand: end index in mode 0, start + count or start + 1 + product
  always_comb begin
    addend = '0;
    cin    = 1'b0;
    case (in_q.func)
      FUNC_OFFSET: begin
        if (in_q.has_counts) begin
          addend = in_q.has_strides ? prod_q : dm1_q;
        end
      end
      FUNC_EDGE: addend = in_q.dim_count;
      FUNC_STRIDE: begin
        addend = prod_q;
        cin    = 1'b1;
      end
      default: addend = '0;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    dim_d       = dim_q;
    sticky_d    = sticky_q;
    offs_d      = offs_q;
    scale_d     = scale_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_data_d  = out_data_q;
    in_d        = in_q;
    dm1_d       = dm1_q;
    prod_d      = prod_q;
    sum_d       = sum_q;
    mreq        = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          in_d = in_data_i;
          if (in_data_i.func == FUNC_NONE) begin
            state_d = S_IDLE;
          end else if (sticky_q == ST_OK && dim_q < nd) begin
            state_d = S_DEC;
          end else begin
            state_d = S_FIN;
          end
        end
      end
      S_DEC: begin
        dm1_d = in_q.dim_count - 64'd1;
        if (in_q.func == FUNC_STRIDE ||
            (in_q.func == FUNC_OFFSET && in_q.has_counts && in_q.has_strides)) begin
          mreq.start = 1'b1;
          mreq.a     = in_q.dim_count - 64'd1;
          mreq.b     = in_q.dim_stride;
          state_d    = S_MUL1;
        end else begin
          state_d = S_SUM;
        end
      end
      S_MUL1: begin
        if (mrsp.done) begin
          prod_d  = mrsp.p;
          state_d = S_SUM;
        end
      end
      S_SUM: begin
        sum_d   = in_q.dim_start + addend + 64'(cin);
        state_d = S_CHECK;
      end
      S_CHECK: begin
        sticky_d = chk;
        if (in_q.func == FUNC_OFFSET && chk == ST_OK) begin
          mreq.start = 1'b1;
          mreq.a     = sum_q;
          if (rec) begin
            mreq.b = {16'd0, record_size_q};
          end else if (last) begin
            mreq.b = {60'd0, elem_size_q};
          end else begin
            mreq.b = {16'd0, in_q.dim_pitch};
          end
          scale_d = !rec && !last;
          state_d = S_MUL2;
        end else begin
          state_d = S_FIN;
        end
      end
      S_MUL2: begin
        if (mrsp.done) begin
          if (scale_q) begin
            mreq.start = 1'b1;
            mreq.a     = mrsp.p;
            mreq.b     = {60'd0, elem_size_q};
            scale_d    = 1'b0;
          end else begin
            offs_d  = offs_q + mrsp.p;
            state_d = S_FIN;
          end
        end
      end
      S_FIN: begin
        if (!in_q.is_last) begin
          if (32'(dim_q) < 32'(MAX_DIMS)) dim_d = dim_q + DIM_W'(1);
          state_d = S_IDLE;
        end else if (!out_valid_q || out_ready_i) begin
          out_valid_d       = 1'b1;
          out_data_d.status = sticky_q;
          if (in_q.func == FUNC_OFFSET && sticky_q == ST_OK) begin
            out_data_d.end_offset = $signed({2'b00, var_begin_q} + offs_q);
          end else begin
            out_data_d.end_offset = '0;
          end
          dim_d    = '0;
          sticky_d = ST_OK;
          offs_d   = '0;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      dim_q       <= '0;
      sticky_q    <= ST_OK;
      offs_q      <= '0;
      scale_q     <= 1'b0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      state_q     <= state_d;
      dim_q       <= dim_d;
      sticky_q    <= sticky_d;
      offs_q      <= offs_d;
      scale_q     <= scale_d;
      out_valid_q <= out_valid_d;
      out_data_q  <= out_data_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_q   <= in_d;
    dm1_q  <= dm1_d;
    prod_q <= prod_d;
    sum_q  <= sum_d;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_mul_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mreq.start |-> (state_q == S_DEC || state_q == S_CHECK || state_q == S_MUL2))
    else $error("multiplier started outside a multiply step");

  a_mul_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MUL1 || state_q == S_MUL2) |-> (mrsp.busy || mrsp.done))
    else $error("waiting on an idle multiplier");

  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_FIN))
    else $error("result raised outside the finish step");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_data_q.status != ST_OK) |-> (out_data_q.end_offset == '0))
    else $error("offset reported with an error status");

  a_dim_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(dim_q) <= 32'(MAX_DIMS))
    else $error("dimension index beyond maximum");

endmodule
